// ===== sv/mjd_pkg.sv =====
// Shared types, constants and the header key table for the multipart stream deframer.
`default_nettype none

package mjd_pkg;

	// Character codes used when classifying stream bytes
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;

	// Length of the "content-length:" key
	localparam int KEY_LEN = 15;

	// Configuration register indexes
	localparam logic [2:0] CFG_BOUNDARY_LENGTH = 3'd0;
	localparam logic [2:0] CFG_BOUNDARY_WORD0  = 3'd1;
	localparam logic [2:0] CFG_BOUNDARY_WORD1  = 3'd2;
	localparam logic [2:0] CFG_BOUNDARY_WORD2  = 3'd3;
	localparam logic [2:0] CFG_BOUNDARY_WORD3  = 3'd4;
	localparam logic [2:0] CFG_MAX_FRAME_LEN   = 3'd5;

	// One classified stream byte, as queued between front and back
	typedef struct packed {
		logic [7:0] data;
		logic [7:0] lower;
		logic [3:0] digit;
		logic       is_lf;
		logic       is_cr;
		logic       is_nul;
		logic       is_digit;
		logic       is_blank;
		logic       is_plus;
		logic       is_minus;
	} mjd_item_t;

	// Configuration as seen by the back end
	typedef struct packed {
		logic [5:0]   boundary_length;
		logic [255:0] boundary;
		logic [23:0]  max_frame_length;
	} mjd_cfg_t;

	// Lowercase header key, one character per column
	function automatic logic [7:0] key_char(input logic [3:0] idx);
		logic [7:0] ch;
		case (idx)
			4'd0: ch = "c";
			4'd1: ch = "o";
			4'd2: ch = "n";
			4'd3: ch = "t";
			4'd4: ch = "e";
			4'd5: ch = "n";
			4'd6: ch = "t";
			4'd7: ch = "-";
			4'd8: ch = "l";
			4'd9: ch = "e";
			4'd10: ch = "n";
			4'd11: ch = "g";
			4'd12: ch = "t";
			4'd13: ch = "h";
			4'd14: ch = ":";
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

`default_nettype wire

// ===== sv/mjd_front.sv =====
// Front end: takes stream bytes and classifies each one for the header parser.
`default_nettype none

module mjd_front (
	input  wire logic             s_axis_tvalid,
	output logic                  s_axis_tready,
	input  wire logic [7:0]       s_axis_tdata,   // [7:0] in_byte
	input  wire logic             q_full,
	output logic                  q_push,
	output mjd_pkg::mjd_item_t    q_item
);
	import mjd_pkg::*;

	logic [7:0] c;

	// Accept whenever the queue has room
	assign s_axis_tready = !q_full;
	assign q_push        = s_axis_tvalid && !q_full;
	assign c             = s_axis_tdata;

	// Character classes
	always_comb begin
		q_item.data     = c;
		q_item.lower    = (c >= CH_UP_A && c <= CH_UP_Z) ? c + 8'd32 : c;
		q_item.digit    = 4'(c - CH_ZERO);
		q_item.is_lf    = (c == CH_LF);
		q_item.is_cr    = (c == CH_CR);
		q_item.is_nul   = (c == CH_NUL);
		q_item.is_digit = (c >= CH_ZERO && c <= CH_NINE);
		q_item.is_blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) ||
			(c == CH_VT) || (c == CH_FF);
		q_item.is_plus  = (c == CH_PLUS);
		q_item.is_minus = (c == CH_MINUS);
	end

endmodule

`default_nettype wire

// ===== sv/mjd_fifo.sv =====
// Short flip-flop queue between front and back ends.
`default_nettype none

module mjd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic                  not_empty,
	output logic [WIDTH-1:0]      head
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wptr_q, rptr_q;
	logic [CNTW-1:0]  count_q;
	logic             do_push, do_pop;

	assign full      = (count_q == CNTW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/mjd_back.sv =====
// Back end: boundary hunt, header parsing, payload transfer and output register.
`default_nettype none

module mjd_back #(
	parameter int MAX_BOUNDARY = 32,
	parameter int LINE_LIMIT   = 1024,
	parameter int LENGTH_BITS  = 24
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire mjd_pkg::mjd_cfg_t   cfg,
	input  wire logic                q_valid,
	input  wire mjd_pkg::mjd_item_t  q_item,
	output logic                     q_pop,
	output logic                     m_axis_tvalid,
	input  wire logic                m_axis_tready,
	output logic [31:0]              m_axis_tdata,   // [7:0] out_byte, [31:8] frame_length
	output logic                     m_axis_tlast,   // frame_last
	output logic                     m_axis_tuser    // [0] result_kind
);
	import mjd_pkg::*;

	localparam int MW = $clog2(MAX_BOUNDARY + 1);
	localparam int CW = $clog2(LINE_LIMIT);
	localparam int LB = LENGTH_BITS;
	localparam logic [CW-1:0] COL_LAST = CW'(LINE_LIMIT - 1);
	localparam logic [CW-1:0] KEY_COL  = CW'(KEY_LEN);
	localparam logic [LB-1:0] CAP      = {LB{1'b1}};

	localparam logic [1:0] PH_HUNT     = 2'd0;
	localparam logic [1:0] PH_SKIPLINE = 2'd1;
	localparam logic [1:0] PH_HEADERS  = 2'd2;
	localparam logic [1:0] PH_PAYLOAD  = 2'd3;

	localparam logic [1:0] NUM_BLANKS = 2'd0;
	localparam logic [1:0] NUM_DIGITS = 2'd1;
	localparam logic [1:0] NUM_DONE   = 2'd2;

	// Parser state
	logic [1:0]    phase_q, phase_d;
	logic [MW-1:0] match_q, match_d;
	logic [CW-1:0] col_q, col_d;
	logic          pend_q, pend_d, fcc_q, fcc_d, pok_q, pok_d;
	logic [1:0]    nph_q, nph_d;
	logic          neg_q, neg_d, ovf_q, ovf_d, bad_q, bad_d;
	logic [LB-1:0] val_q, val_d, dl_q, dl_d, left_q, left_d;

	// Output register
	logic          ovalid_q, okind_q, olast_q;
	logic [7:0]    obyte_q;
	logic [23:0]   olen_q;

	// Working values
	logic          go, emit, e_kind, e_last;
	logic [7:0]    e_byte;
	logic [23:0]   dl_sat;
	logic [7:0]    blen, bidx, mc_next;
	logic [7:0]    bnd_b;
	logic          cr_store, c_store, do_add, line_end, hdr_end, set_len, reject;
	logic [CW-1:0] col_a, col_b;
	logic          fcc_a, pok_a, fcc_b, pok_b, neg_b, ovf_b, new_bad;
	logic [1:0]    nph_a, nph_b;
	logic [LB-1:0] val_b, new_dl;
	logic [LB+3:0] prod;

	// Pop when the output slot is free or draining
	assign go    = q_valid && (!ovalid_q || m_axis_tready);
	assign q_pop = go;

	// Effective boundary length and expected boundary byte
	always_comb begin
		blen = (cfg.boundary_length == 6'd0) ? 8'd1 : {2'b00, cfg.boundary_length};
		if (blen > 8'(MAX_BOUNDARY)) begin
			blen = 8'(MAX_BOUNDARY);
		end
		bidx    = 8'(match_q);
		mc_next = bidx + 8'd1;
		bnd_b   = (bidx < 8'd32) ? cfg.boundary[{bidx[4:0], 3'b000} +: 8] : 8'h00;
	end

	// Declared length, saturated for output, and the reject test
	always_comb begin
		dl_sat = (32'(dl_q) > 32'h00FF_FFFF) ? 24'hFF_FFFF : 24'(dl_q);
		reject = bad_q || (dl_q == '0) || (32'(dl_q) > 32'(cfg.max_frame_length));
	end

	// Header line: a held CR stored first, then the current byte
	always_comb begin
		col_a = col_q;
		fcc_a = fcc_q;
		pok_a = pok_q;
		nph_a = nph_q;
		cr_store = pend_q && !q_item.is_lf;
		if (cr_store) begin
			if (col_q == '0) begin
				fcc_a = 1'b1;
			end
			if (col_q < KEY_COL) begin
				pok_a = 1'b0;
			end else if (pok_q && nph_q == NUM_DIGITS) begin
				nph_a = NUM_DONE;
			end
			col_a = col_q + 1'b1;
		end

		col_b  = col_a;
		fcc_b  = fcc_a;
		pok_b  = pok_a;
		nph_b  = nph_a;
		neg_b  = neg_q;
		ovf_b  = ovf_q;
		val_b  = val_q;
		do_add = 1'b0;
		c_store = !q_item.is_lf && (pend_q ? (col_a < COL_LAST) : !q_item.is_cr);
		if (c_store) begin
			if (col_a == '0 && (q_item.is_cr || q_item.is_nul)) begin
				fcc_b = 1'b1;
			end
			if (col_a < KEY_COL) begin
				if (q_item.lower != key_char(col_a[3:0])) begin
					pok_b = 1'b0;
				end
			end else if (pok_a) begin
				case (nph_a)
					NUM_BLANKS: begin
						if (q_item.is_blank) begin
							nph_b = NUM_BLANKS;
						end else if (q_item.is_plus || q_item.is_minus) begin
							neg_b = q_item.is_minus;
							nph_b = NUM_DIGITS;
						end else if (q_item.is_digit) begin
							nph_b  = NUM_DIGITS;
							do_add = 1'b1;
						end else begin
							nph_b = NUM_DONE;
						end
					end
					NUM_DIGITS: begin
						if (q_item.is_digit) begin
							do_add = 1'b1;
						end else begin
							nph_b = NUM_DONE;
						end
					end
					default: begin
						nph_b = nph_a;
					end
				endcase
			end
			col_b = col_a + 1'b1;
		end

		// Decimal accumulate, saturating
		prod = ({4'b0000, val_q} << 3) + ({4'b0000, val_q} << 1) + (LB+4)'(q_item.digit);
		if (do_add) begin
			if (prod > (LB+4)'(CAP)) begin
				val_b = CAP;
				ovf_b = 1'b1;
			end else begin
				val_b = prod[LB-1:0];
			end
		end

		line_end = q_item.is_lf || (col_b >= COL_LAST);
		hdr_end  = (col_b == '0) || fcc_b;
		set_len  = pok_b && (col_b >= KEY_COL);
		new_bad  = ovf_b || (neg_b && val_b != '0);
		new_dl   = new_bad ? CAP : val_b;
	end

	// Next state and result
	always_comb begin
		phase_d = phase_q;
		match_d = match_q;
		col_d   = col_q;
		pend_d  = pend_q;
		fcc_d   = fcc_q;
		pok_d   = pok_q;
		nph_d   = nph_q;
		neg_d   = neg_q;
		ovf_d   = ovf_q;
		val_d   = val_q;
		bad_d   = bad_q;
		dl_d    = dl_q;
		left_d  = left_q;
		emit    = 1'b0;
		e_kind  = 1'b0;
		e_byte  = 8'h00;
		e_last  = 1'b0;

		if (go) begin
			case (phase_q)
				PH_HUNT: begin
					if (q_item.data == bnd_b) begin
						if (mc_next >= blen) begin
							match_d = '0;
							phase_d = PH_SKIPLINE;
						end else begin
							match_d = match_q + 1'b1;
						end
					end else begin
						match_d = '0;
					end
				end
				PH_SKIPLINE: begin
					if (q_item.is_lf) begin
						phase_d = PH_HEADERS;
						col_d   = '0;
						pend_d  = 1'b0;
						fcc_d   = 1'b0;
						pok_d   = 1'b1;
						nph_d   = NUM_BLANKS;
						neg_d   = 1'b0;
						ovf_d   = 1'b0;
						val_d   = '0;
						dl_d    = '0;
						bad_d   = 1'b0;
					end
				end
				PH_HEADERS: begin
					if (line_end) begin
						col_d  = '0;
						pend_d = 1'b0;
						fcc_d  = 1'b0;
						pok_d  = 1'b1;
						nph_d  = NUM_BLANKS;
						neg_d  = 1'b0;
						ovf_d  = 1'b0;
						val_d  = '0;
						if (hdr_end) begin
							if (reject) begin
								phase_d = PH_HUNT;
								match_d = '0;
								emit    = 1'b1;
								e_kind  = 1'b1;
							end else begin
								phase_d = PH_PAYLOAD;
								left_d  = dl_q;
							end
						end else if (set_len) begin
							bad_d = new_bad;
							dl_d  = new_dl;
						end
					end else begin
						col_d  = col_b;
						fcc_d  = fcc_b;
						pok_d  = pok_b;
						nph_d  = nph_b;
						neg_d  = neg_b;
						ovf_d  = ovf_b;
						val_d  = val_b;
						pend_d = !pend_q && q_item.is_cr;
					end
				end
				default: begin
					// Payload byte
					e_last = (left_q <= LB'(1));
					left_d = e_last ? '0 : left_q - 1'b1;
					if (e_last) begin
						phase_d = PH_HUNT;
						match_d = '0;
					end
					emit   = 1'b1;
					e_byte = q_item.data;
				end
			endcase
		end
	end

	// Parser registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			match_q <= '0;
			col_q   <= '0;
			pend_q  <= 1'b0;
			fcc_q   <= 1'b0;
			pok_q   <= 1'b0;
			nph_q   <= NUM_BLANKS;
			neg_q   <= 1'b0;
			ovf_q   <= 1'b0;
			val_q   <= '0;
			bad_q   <= 1'b0;
			dl_q    <= '0;
			left_q  <= '0;
		end else begin
			phase_q <= phase_d;
			match_q <= match_d;
			col_q   <= col_d;
			pend_q  <= pend_d;
			fcc_q   <= fcc_d;
			pok_q   <= pok_d;
			nph_q   <= nph_d;
			neg_q   <= neg_d;
			ovf_q   <= ovf_d;
			val_q   <= val_d;
			bad_q   <= bad_d;
			dl_q    <= dl_d;
			left_q  <= left_d;
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (go && emit) begin
			ovalid_q <= 1'b1;
		end else if (m_axis_tready) begin
			ovalid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (go && emit) begin
			okind_q <= e_kind;
			obyte_q <= e_byte;
			olast_q <= e_last;
			olen_q  <= dl_sat;
		end
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = {olen_q, obyte_q};
	assign m_axis_tlast  = olast_q;
	assign m_axis_tuser  = okind_q;

endmodule

`default_nettype wire

// ===== sv/multipart_jpeg_stream_deframer_core.sv =====
// Top level of the multipart stream deframer: config registers, front, queue and back.
//
// Channel   Dir  Handshake                   Payload
// s_axis    in   s_axis_tvalid/tready        tdata[7:0] in_byte
// m_axis    out  m_axis_tvalid/tready        tdata[7:0] out_byte, [31:8] frame_length;
//                                            tlast frame_last; tuser[0] result_kind
// cfg       in   cfg_valid/cfg_ready         cfg_index register, cfg_data value
//
// One byte per clock sustained while the output is not stalled; the back end then
// retires one queued byte each cycle. A byte enters the queue at its transfer edge,
// and its result is registered in the output register when the back end pops it.
// A stalled output stops the back end; the front keeps taking bytes until the
// queue (QUEUE_DEPTH entries) fills. Reset is asynchronous and needs no clear pass.
// Configuration writes are always accepted (cfg_ready is tied high) and take effect at once.
`default_nettype none

module multipart_jpeg_stream_deframer_core #(
	parameter int MAX_BOUNDARY = 32,
	parameter int LINE_LIMIT   = 1024,
	parameter int LENGTH_BITS  = 24,
	parameter int QUEUE_DEPTH  = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,   // [7:0] out_byte, [31:8] frame_length
	output logic             m_axis_tlast,   // frame_last
	output logic             m_axis_tuser,   // [0] result_kind
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);
	import mjd_pkg::*;

	localparam int IW = $bits(mjd_item_t);

	logic [5:0]  blen_q;
	logic [63:0] word0_q, word1_q, word2_q, word3_q;
	logic [23:0] maxlen_q;
	mjd_cfg_t    cfg;

	logic        q_push, q_full, q_pop, q_valid;
	mjd_item_t   push_item, head_item;
	logic [IW-1:0] head_bits;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blen_q   <= 6'd10;
			word0_q  <= 64'h6164_6E75_6F62_2D2D;
			word1_q  <= 64'h0000_0000_0000_7972;
			word2_q  <= '0;
			word3_q  <= '0;
			maxlen_q <= 24'd10485760;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_BOUNDARY_LENGTH: blen_q   <= cfg_data[5:0];
				CFG_BOUNDARY_WORD0:  word0_q  <= cfg_data;
				CFG_BOUNDARY_WORD1:  word1_q  <= cfg_data;
				CFG_BOUNDARY_WORD2:  word2_q  <= cfg_data;
				CFG_BOUNDARY_WORD3:  word3_q  <= cfg_data;
				CFG_MAX_FRAME_LEN:   maxlen_q <= cfg_data[23:0];
				default: begin
					blen_q <= blen_q;
				end
			endcase
		end
	end

	assign cfg.boundary_length  = blen_q;
	assign cfg.boundary         = {word3_q, word2_q, word1_q, word0_q};
	assign cfg.max_frame_length = maxlen_q;

	// Front end: accept and classify
	mjd_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_item        (push_item)
	);

	// Queue between front and back
	mjd_fifo #(
		.WIDTH (IW),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.head      (head_bits)
	);

	assign head_item = mjd_item_t'(head_bits);

	// Back end: parse and emit
	mjd_back #(
		.MAX_BOUNDARY (MAX_BOUNDARY),
		.LINE_LIMIT   (LINE_LIMIT),
		.LENGTH_BITS  (LENGTH_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.q_valid       (q_valid),
		.q_item        (head_item),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

`default_nettype wire

// ===== bench/multipart_jpeg_stream_deframer_core_tb.sv =====
// Self-checking testbench for the multipart stream deframer: boundary hunt, headers, payload.
`default_nettype none

module multipart_jpeg_stream_deframer_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mjd_pkg::*;

	localparam int          LINE_MAX = 1023;
	localparam logic [23:0] LEN_CAP  = 24'hFFFFFF;
	localparam logic [8*15-1:0] KEY_TEXT = "content-length:";
	localparam logic [7:0]  CH_LOW_A = 8'h61;
	localparam logic [7:0]  CH_LOW_Z = 8'h7A;

	typedef enum logic [1:0] {ST_HUNT, ST_SKIP_LINE, ST_HEADERS, ST_PAYLOAD} deframe_phase_t;
	typedef enum logic [1:0] {NUM_BLANKS, NUM_DIGITS, NUM_DONE} num_phase_t;
	typedef enum logic {KIND_PAYLOAD, KIND_REJECT} beat_kind_t;

	typedef struct packed {
		beat_kind_t  kind;
		logic [7:0]  data;
		logic        last;
		logic [23:0] length;
	} frame_beat_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;    // [7:0] in_byte
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;            // [7:0] out_byte, [31:8] frame_length
	logic        m_axis_tlast;            // frame_last
	logic        m_axis_tuser;            // [0] result_kind
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = CFG_BOUNDARY_LENGTH;
	logic [63:0] cfg_data = 64'd0;

	multipart_jpeg_stream_deframer_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// Bench copy of the register file
	logic [5:0]   cfg_blen;
	logic [255:0] cfg_bnd;
	logic [23:0]  cfg_max;

	// Bench copy of the deframer state
	deframe_phase_t phase;
	num_phase_t     num_st;
	int             hunt_cnt;
	int             col;
	bit             cr_held, lead_cr, key_ok, minus, sat, len_bad;
	logic [23:0]    acc, decl_len, remain;

	logic [7:0]  byte_feed[$];
	frame_beat_t beats_due[$];
	int          errors = 0;
	int          fed = 0;
	bit          s_fire = 1'b0;
	bit          m_fire = 1'b0;
	bit          long_hold = 1'b0;
	int          tx_wait = 0, tx_run = 0, rx_wait = 0, rx_run = 0;
	bit          tx_quiet = 1'b0, rx_quiet = 1'b0;

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int bnd_span(logic [5:0] n);
		if (n == 6'd0) return 1;
		if (n > 6'd32) return 32;
		return int'(n);
	endfunction

	function automatic void line_reset();
		col = 0;
		cr_held = 1'b0;
		lead_cr = 1'b0;
		key_ok = 1'b1;
		num_st = NUM_BLANKS;
		minus = 1'b0;
		sat = 1'b0;
		acc = '0;
	endfunction

	function automatic void deframer_reset();
		cfg_blen = 6'd10;
		cfg_bnd = {128'd0, 64'h0000_0000_0000_7972, 64'h6164_6E75_6F62_2D2D};
		cfg_max = 24'd10485760;
		phase = ST_HUNT;
		hunt_cnt = 0;
		line_reset();
		key_ok = 1'b0;
		len_bad = 1'b0;
		decl_len = '0;
		remain = '0;
	endfunction

	function automatic void apply_reg(logic [2:0] idx, logic [63:0] val);
		case (idx)
			CFG_BOUNDARY_LENGTH: cfg_blen = val[5:0];
			CFG_BOUNDARY_WORD0:  cfg_bnd[63:0] = val;
			CFG_BOUNDARY_WORD1:  cfg_bnd[127:64] = val;
			CFG_BOUNDARY_WORD2:  cfg_bnd[191:128] = val;
			CFG_BOUNDARY_WORD3:  cfg_bnd[255:192] = val;
			CFG_MAX_FRAME_LEN:   cfg_max = val[23:0];
			default: ;
		endcase
	endfunction

	// Decimal accumulate with saturation at the length cap
	function automatic void push_digit(logic [7:0] c);
		logic [31:0] v;
		logic [31:0] d;
		d = {24'd0, c} - {24'd0, CH_ZERO};
		v = {8'd0, acc} * 32'd10 + d;
		if (v > {8'd0, LEN_CAP}) begin
			acc = LEN_CAP;
			sat = 1'b1;
		end else begin
			acc = v[23:0];
		end
	endfunction

	// atol-style scan of the text after the key
	function automatic void scan_number(logic [7:0] c);
		bit dig;
		dig = (c >= CH_ZERO) && (c <= CH_NINE);
		case (num_st)
			NUM_BLANKS: begin
				if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_VT || c == CH_FF) begin
				end else if (c == CH_PLUS || c == CH_MINUS) begin
					minus = (c == CH_MINUS);
					num_st = NUM_DIGITS;
				end else if (dig) begin
					num_st = NUM_DIGITS;
					push_digit(c);
				end else begin
					num_st = NUM_DONE;
				end
			end
			NUM_DIGITS: begin
				if (dig) push_digit(c);
				else num_st = NUM_DONE;
			end
			default: ;
		endcase
	endfunction

	function automatic void keep_char(logic [7:0] c);
		logic [7:0] lc;
		if (col == 0 && (c == CH_CR || c == CH_NUL)) lead_cr = 1'b1;
		if (col < KEY_LEN) begin
			lc = (c >= CH_UP_A && c <= CH_UP_Z) ? c + 8'd32 : c;
			if (lc != KEY_TEXT[8*(KEY_LEN-1-col) +: 8]) key_ok = 1'b0;
		end else if (key_ok) begin
			scan_number(c);
		end
		col++;
	endfunction

	// Line finished: either end of headers or a possible length header
	function automatic bit close_line(output frame_beat_t r);
		r = '0;
		if (col == 0 || lead_cr) begin
			line_reset();
			if (len_bad || decl_len == 24'd0 || decl_len > cfg_max) begin
				phase = ST_HUNT;
				hunt_cnt = 0;
				r.kind = KIND_REJECT;
				r.length = decl_len;
				return 1'b1;
			end
			phase = ST_PAYLOAD;
			remain = decl_len;
			return 1'b0;
		end
		if (key_ok && col >= KEY_LEN) begin
			len_bad = sat || (minus && acc != 24'd0);
			decl_len = len_bad ? LEN_CAP : acc;
		end
		line_reset();
		return 1'b0;
	endfunction

	function automatic bit header_byte(logic [7:0] c, output frame_beat_t r);
		r = '0;
		if (cr_held) begin
			cr_held = 1'b0;
			if (c == CH_LF) return close_line(r);
			keep_char(CH_CR);
			if (col < LINE_MAX) keep_char(c);
		end else if (c == CH_LF) begin
			return close_line(r);
		end else if (c == CH_CR) begin
			cr_held = 1'b1;
			return 1'b0;
		end else begin
			keep_char(c);
		end
		if (col >= LINE_MAX) return close_line(r);
		return 1'b0;
	endfunction

	// Advance the deframer by one stream byte; returns 1 when a beat comes out
	function automatic bit deframe_byte(logic [7:0] c, output frame_beat_t r);
		bit got;
		got = 1'b0;
		r = '0;
		case (phase)
			ST_HUNT: begin
				if (c == cfg_bnd[8*hunt_cnt +: 8]) begin
					hunt_cnt++;
					if (hunt_cnt >= bnd_span(cfg_blen)) begin
						hunt_cnt = 0;
						phase = ST_SKIP_LINE;
					end
				end else begin
					hunt_cnt = 0;
				end
			end
			ST_SKIP_LINE: begin
				if (c == CH_LF) begin
					phase = ST_HEADERS;
					line_reset();
					decl_len = '0;
					len_bad = 1'b0;
				end
			end
			ST_HEADERS: got = header_byte(c, r);
			default: begin
				got = 1'b1;
				r.kind = KIND_PAYLOAD;
				r.data = c;
				r.last = (remain <= 24'd1);
				r.length = decl_len;
				if (remain <= 24'd1) begin
					remain = '0;
					phase = ST_HUNT;
					hunt_cnt = 0;
				end else begin
					remain = remain - 24'd1;
				end
			end
		endcase
		return got;
	endfunction

	function automatic void check_field(string name, logic [23:0] want, logic [23:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	// Wait per transfer; each side runs in stretches, each picked at random as idle-free or gappy
	function automatic int draw_wait(inout int run_left, inout bit quiet);
		if (run_left <= 0) begin
			quiet = ($urandom_range(0, 2) == 0);
			run_left = $urandom_range(20, 200);
		end
		run_left--;
		if (quiet || $urandom_range(0, 2) != 0) return 0;
		return $urandom_range(0, 17);
	endfunction

	// Predict on input transfers, check output transfers
	always @(posedge clk) begin
		frame_beat_t nb;
		frame_beat_t want;
		s_fire = arst_n && s_axis_tvalid && s_axis_tready;
		m_fire = arst_n && m_axis_tvalid && m_axis_tready;
		if (s_fire) begin
			if (deframe_byte(s_axis_tdata, nb)) beats_due.push_back(nb);
		end
		if (m_fire) begin
			if (beats_due.size() == 0) begin
				$display("%0t ns: unexpected result, expected none, actual tdata %h tlast %b tuser %b",
					$time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
				errors++;
			end else begin
				want = beats_due.pop_front();
				check_field("result_kind", {23'd0, want.kind}, {23'd0, m_axis_tuser});
				check_field("out_byte", {16'd0, want.data}, {16'd0, m_axis_tdata[7:0]});
				check_field("frame_last", {23'd0, want.last}, {23'd0, m_axis_tlast});
				check_field("frame_length", want.length, m_axis_tdata[31:8]);
			end
		end
	end

	// Stream driver
	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || s_fire) begin
			if (s_fire) tx_wait = draw_wait(tx_run, tx_quiet);
			if (tx_wait > 0) begin
				tx_wait--;
				s_axis_tvalid <= 1'b0;
			end else if (byte_feed.size() != 0) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= byte_feed.pop_front();
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Result receiver
	always @(negedge clk) begin
		if (m_fire) rx_wait = draw_wait(rx_run, rx_quiet);
		if (long_hold || !arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (rx_wait > 0) begin
			rx_wait--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Stimulus building blocks
	function automatic void put(logic [7:0] b);
		byte_feed.push_back(b);
		fed++;
	endfunction

	function automatic void put_text(string s);
		for (int i = 0; i < s.len(); i++) put(s[i]);
	endfunction

	function automatic void put_line(string s, bit crlf);
		put_text(s);
		if (crlf) put(CH_CR);
		put(CH_LF);
	endfunction

	function automatic void put_eol();
		if ($urandom_range(0, 1)) put(CH_CR);
		put(CH_LF);
	endfunction

	function automatic void put_boundary();
		for (int i = 0; i < bnd_span(cfg_blen); i++) put(cfg_bnd[8*i +: 8]);
	endfunction

	function automatic logic [7:0] printable();
		return 8'($urandom_range(32, 126));
	endfunction

	function automatic void put_junk_line();
		put_text("X-");
		repeat ($urandom_range(1, 10)) put(printable());
		put_eol();
	endfunction

	// Length header with random key case, blanks, sign, zeros and trailer
	function automatic void put_length_line(string num);
		logic [7:0] c;
		string key;
		int pick;
		key = "content-length:";
		for (int i = 0; i < key.len(); i++) begin
			c = key[i];
			if (c >= CH_LOW_A && c <= CH_LOW_Z && $urandom_range(0, 1)) c = c - 8'd32;
			put(c);
		end
		repeat ($urandom_range(0, 2)) begin
			pick = $urandom_range(0, 4);
			case (pick)
				0: put(CH_SPACE);
				1: put(CH_TAB);
				2: put(CH_VT);
				3: put(CH_FF);
				default: put(CH_CR);
			endcase
		end
		if (num[0] >= CH_ZERO && num[0] <= CH_NINE) begin
			if ($urandom_range(0, 3) == 0) put(CH_PLUS);
			else if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) put(CH_ZERO);
		end
		put_text(num);
		if ($urandom_range(0, 3) == 0) put_text(" bytes");
		put_eol();
	endfunction

	// One multipart section, mostly well formed, with noise and broken pieces mixed in
	function automatic void random_frame();
		int len;
		int pick;
		int cap;
		int k;
		longint over;
		logic [7:0] b;
		len = 0;
		if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 6)) put(8'($urandom_range(0, 255)));
		if ($urandom_range(0, 11) == 0) begin
			k = $urandom_range(0, bnd_span(cfg_blen) - 1);
			for (int i = 0; i < k; i++) put(cfg_bnd[8*i +: 8]);
			put(8'($urandom_range(0, 255)));
		end
		put_boundary();
		repeat ($urandom_range(0, 3)) begin
			b = 8'($urandom_range(0, 255));
			put(b == CH_LF ? CH_SPACE : b);
		end
		put_eol();
		if ($urandom_range(0, 2) == 0) put_junk_line();
		pick = $urandom_range(0, 9);
		if (pick != 4 && $urandom_range(0, 3) == 0)
			put_length_line($sformatf("%0d", $urandom_range(0, 99999)));
		case (pick)
			0: put_length_line("0");
			1: put_length_line($sformatf("-%0d", $urandom_range(1, 500)));
			2: begin
				over = longint'(cfg_max) + longint'($urandom_range(1, 1000));
				put_length_line($sformatf("%0d", over));
			end
			3: put_length_line("123456789012");
			4: ;
			default: begin
				cap = (cfg_max < 24'd12) ? int'(cfg_max) : 12;
				len = $urandom_range(1, cap);
				put_length_line($sformatf("%0d", len));
			end
		endcase
		if ($urandom_range(0, 2) == 0) put_junk_line();
		// End of headers: empty line, or a line led by CR or NUL
		pick = $urandom_range(0, 7);
		if (pick == 6) begin
			put(CH_CR);
			put(printable());
			put_eol();
		end else if (pick == 7) begin
			put(CH_NUL);
			put(printable());
			put_eol();
		end else begin
			put_eol();
		end
		repeat (len) put(8'($urandom_range(0, 255)));
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		apply_reg(idx, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Wait until all bytes went in and every beat came out, plus pipeline slack
	task automatic drain();
		while (byte_feed.size() != 0 || s_axis_tvalid || beats_due.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic random_phase(input int target);
		fed = 0;
		while (fed < target) random_frame();
		drain();
	endtask

	function automatic void directed_frames();
		// Plain frame with CRLF lines
		put_text("--boundary");
		put_line(" tail", 1);
		put_line("Content-Type: image/jpeg", 1);
		put_line("Content-Length: 3", 1);
		put_line("", 1);
		put(8'h00); put(8'hFF); put(8'h5A);
		// Extra dash breaks the match and is not compared again; lone CR; last length wins
		put_text("---boundary");
		put_text("x--boundary");
		put_line("", 0);
		put_text("X-Note: a");
		put(CH_CR);
		put_line("b", 0);
		put_line("content-length: 99", 0);
		put_line("CONTENT-length:\t+0005", 0);
		put_line("", 0);
		put(8'h0A); put(8'h0D); put(8'h2D); put(8'h80); put(8'h7F);
		// Rejects: zero, negative, minus zero, over the limit, overflow, none, no digits
		put_text("--boundary"); put_line("", 0); put_line("Content-Length: 0", 0); put_line("", 0);
		put_text("--boundary"); put_line("", 0); put_line("Content-Length:  -7", 1); put_line("", 1);
		put_text("--boundary"); put_line("", 0); put_line("Content-Length: -0", 0); put_line("", 0);
		put_text("--boundary"); put_line("", 0); put_line("Content-Length: 10485761", 0);
		put_line("", 0);
		put_text("--boundary"); put_line("", 0); put_line("Content-Length: 99999999999", 0);
		put_line("", 0);
		put_text("--boundary"); put_line("", 0); put_line("X-A: b", 0); put_line("", 0);
		put_text("--boundary"); put_line("", 0); put_line("Content-Length: abc", 0); put_line("", 0);
		// Bare key, then a length, then headers closed by a line led by CR
		put_text("--boundary"); put_line("", 0);
		put_line("Content-Length:", 0);
		put_line("Content-Length: 2", 0);
		put(CH_CR); put_line("Z", 0);
		put(8'h31); put(8'h32);
		// Headers closed by a line led by NUL; a key without colon does not count
		put_text("--boundary"); put_line("", 0);
		put_line("Content-Length: 1", 0);
		put_line("Content-Length", 0);
		put(CH_NUL); put_line("q", 0);
		put(8'hA5);
		// Full-length line ends on its own; the LF after it is an empty line
		put_text("--boundary"); put_line("", 0);
		put_text("Content-Length: 2");
		repeat (LINE_MAX - 17) put("y");
		put(CH_LF);
		put(8'h01); put(8'hFE);
		// Stored CR fills the line and the byte after it is dropped
		put_text("--boundary"); put_line("", 0);
		put_text("Content-Length: 3");
		repeat (LINE_MAX - 18) put("y");
		put(CH_CR);
		put("W");
		put(CH_LF);
		put(8'h55); put(8'hAA); put(8'h0F);
	endfunction

	// Main sequence
	initial begin
		logic [63:0] w;
		deframer_reset();
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset configuration
		directed_frames();
		drain();
		fed = 0;
		while (fed < 150) random_frame();
		// Receiver holds off while the sender keeps going
		long_hold = 1'b1;
		repeat (300) @(posedge clk);
		long_hold = 1'b0;
		random_phase(60);

		// Shortest boundary, smallest frame limit
		w = {$urandom, $urandom};
		write_reg(CFG_BOUNDARY_LENGTH, {w[63:6], 6'd1});
		write_reg(CFG_BOUNDARY_WORD0, {$urandom, $urandom});
		w = {$urandom, $urandom};
		write_reg(CFG_MAX_FRAME_LEN, {w[63:24], 24'd1});
		random_phase(140);

		// Longest boundary, largest frame limit
		write_reg(CFG_BOUNDARY_LENGTH, 64'd32);
		write_reg(CFG_BOUNDARY_WORD0, {$urandom, $urandom});
		write_reg(CFG_BOUNDARY_WORD1, {$urandom, $urandom});
		write_reg(CFG_BOUNDARY_WORD2, {$urandom, $urandom});
		write_reg(CFG_BOUNDARY_WORD3, {$urandom, $urandom});
		write_reg(CFG_MAX_FRAME_LEN, 64'hFFFF_FFFF_FFFF_FFFF);
		random_phase(180);

		// Length above the maximum clamps to 32
		write_reg(CFG_BOUNDARY_LENGTH, 64'd63);
		write_reg(CFG_BOUNDARY_WORD2, {$urandom, $urandom});
		write_reg(CFG_MAX_FRAME_LEN, 64'($urandom_range(13, 4000)));
		random_phase(140);

		// Length zero acts as one; middle-size frame limit
		write_reg(CFG_BOUNDARY_LENGTH, 64'd0);
		write_reg(CFG_BOUNDARY_WORD0, {$urandom, $urandom});
		write_reg(CFG_MAX_FRAME_LEN, 64'($urandom_range(2, 11)));
		random_phase(120);

		if (errors == 0) begin
			$display("multipart_jpeg_stream_deframer_core_tb: done, clean");
		end else begin
			$display("multipart_jpeg_stream_deframer_core_tb: done, errors");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#6000000;
		$display("multipart_jpeg_stream_deframer_core_tb: done, errors");
		$finish;
	end

endmodule

`default_nettype wire

// ===== multipart_jpeg_stream_deframer_core.f =====
sv/mjd_pkg.sv
sv/mjd_front.sv
sv/mjd_fifo.sv
sv/mjd_back.sv
sv/multipart_jpeg_stream_deframer_core.sv
bench/multipart_jpeg_stream_deframer_core_tb.sv
